### sv/nearest_neighbor_tour_macros.svh
// Assertion macros shared by the nearest-neighbor tour RTL.
`ifndef NEAREST_NEIGHBOR_TOUR_MACROS_SVH
`define NEAREST_NEIGHBOR_TOUR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define NNT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest_neighbor_tour: same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define NNT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest_neighbor_tour: next-cycle check failed");
`else
`define NNT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NNT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### sv/nnt_pkg.sv
// Shared types and fixed constants of the nearest-neighbor tour block.
package nnt_pkg;

  // Fixed field widths of the ports.
  localparam int WIN_BITS   = 16;
  localparam int POS_BITS   = 5;
  localparam int VTX_BITS   = 5;
  localparam int STEP_BITS  = 16;
  localparam int COUNT_BITS = 6;
  localparam int START_BITS = 5;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_VERTEX = 1'b1;

  // Control from the sequencer to the shared minimum unit.
  typedef struct packed {
    logic clear;
    logic sample;
  } nnt_min_ctl_t;

endpackage

### sv/nearest_neighbor_tour.sv
// Top level: weight matrix loader and greedy nearest-neighbor tour sequencer.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_ready   weight
//   output    out        out_valid / out_ready position, vertex, step_weight,
//                                              last_of_tour, bad_start
//   config    in         cfg_we                cfg_index, cfg_data
//
// Each weight item that is taken is written to the weight RAM.
// The item that completes the n-by-n matrix starts a tour. Each later tour position
// scans one matrix row, one entry per cycle, then passes the drain and next states.
// in_ready stays low until the last result is loaded into the output register, and
// a stalled output holds the sequencer before each result. Reset is synchronous.
`include "nearest_neighbor_tour_macros.svh"

module nearest_neighbor_tour
  import nnt_pkg::*;
#(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [WIN_BITS-1:0]      weight,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POS_BITS-1:0]      position,
  output logic [VTX_BITS-1:0]      vertex,
  output logic [STEP_BITS-1:0]     step_weight,
  output logic                     last_of_tour,
  output logic                     bad_start
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int AW1   = $clog2(DEPTH + 1);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int CMPW  = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int SCW   = (CW > START_BITS) ? CW : START_BITS;
  localparam int KEEP  = (WEIGHT_BITS < WIN_BITS) ? WEIGHT_BITS : WIN_BITS;

  // Sequencer states.
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_ROW   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_NEXT  = 3'd4;

  logic [2:0]              state;
  logic [COUNT_BITS-1:0]   vertex_count;
  logic [START_BITS-1:0]   origin_vertex;
  logic [AW-1:0]           load_counter;
  logic [VW-1:0]           cur;
  logic [VW-1:0]           pos;
  logic [WEIGHT_BITS-1:0]  wstep;
  logic                    bad;
  logic [MAX_VERTICES-1:0] visited;
  logic [AW-1:0]           row_base;
  logic [VW-1:0]           scan_i;
  logic                    rd_v;
  logic [VW-1:0]           rd_i;

  logic [CW-1:0]           n_eff;
  logic [AW1-1:0]          nn;
  logic [AW1-1:0]          row_prod;
  logic [VW-1:0]           n_last;
  logic                    in_fire;
  logic                    tour_go;
  logic                    start_bad;
  logic [VW-1:0]           start_cur;
  logic                    out_free;
  logic                    emit;
  logic                    last_pos;
  logic [WEIGHT_BITS-1:0]  w_keep;
  logic [STEP_BITS-1:0]    step16;
  logic [AW-1:0]           raddr;
  logic [WEIGHT_BITS-1:0]  rdata;
  logic [VW-1:0]           best_index;
  logic [WEIGHT_BITS-1:0]  best_weight;
  nnt_min_ctl_t            min_ctl;

  // Effective vertex count: zero acts as one, large values saturate.
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = CW'(1);
    end else if (CMPW'(vertex_count) > CMPW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vertex_count);
    end
  end

  assign nn       = AW1'(n_eff) * AW1'(n_eff);
  assign row_prod = AW1'(cur) * AW1'(n_eff);
  assign n_last   = VW'(n_eff - CW'(1));

  assign in_ready = (state == S_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign tour_go  = (AW1'(load_counter) + AW1'(1)) >= nn;

  // An out-of-range start vertex falls back to vertex zero.
  assign start_bad = SCW'(origin_vertex) >= SCW'(n_eff);
  assign start_cur = start_bad ? '0 : VW'(origin_vertex);

  assign out_free = !out_valid || out_ready;
  assign emit     = (state == S_ROW) && out_free;
  assign last_pos = (CW'(pos) + CW'(1)) == n_eff;

  // Keep the low weight bits on the way in, widen them on the way out.
  always_comb begin
    w_keep = '0;
    step16 = '0;
    for (int b = 0; b < KEEP; b++) begin
      w_keep[b] = weight[b];
      step16[b] = wstep[b];
    end
  end

  assign raddr = row_base + AW'(scan_i);

  nnt_ram #(
    .WIDTH(WEIGHT_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (in_fire),
    .waddr(load_counter),
    .wdata(w_keep),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign min_ctl.clear  = emit;
  assign min_ctl.sample = rd_v;

  nnt_argmin #(
    .IDX_BITS   (VW),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_min (
    .clk        (clk),
    .rst        (rst),
    .ctl        (min_ctl),
    .cand_index (rd_i),
    .cand_weight(rdata),
    .cand_skip  (visited[rd_i]),
    .best_index (best_index),
    .best_weight(best_weight)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= COUNT_BITS'(32);
      origin_vertex <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count  <= cfg_data;
        REG_ORIGIN_VERTEX: origin_vertex <= cfg_data[START_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Load counter, tour sequencer and visited map.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      load_counter <= '0;
      cur          <= '0;
      pos          <= '0;
      visited      <= '0;
      rd_v         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rd_v <= (state == S_SCAN);
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (tour_go) begin
              load_counter <= '0;
              cur          <= start_cur;
              pos          <= '0;
              visited      <= '0;
              state        <= S_ROW;
            end else begin
              load_counter <= load_counter + AW'(1);
            end
          end
        end
        S_ROW: begin
          if (out_free) begin
            visited[cur] <= 1'b1;
            state        <= last_pos ? S_LOAD : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_i == n_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_NEXT;
        end
        S_NEXT: begin
          cur   <= best_index;
          pos   <= pos + VW'(1);
          state <= S_ROW;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Datapath registers of the tour.
  always_ff @(posedge clk) begin
    rd_i <= scan_i;
    if (in_fire && tour_go) begin
      bad   <= start_bad;
      wstep <= '0;
    end
    if (state == S_NEXT) begin
      wstep <= best_weight;
    end
    if (emit) begin
      row_base <= row_prod[AW-1:0];
      scan_i   <= '0;
    end else if (state == S_SCAN) begin
      scan_i <= scan_i + VW'(1);
    end
  end

  // Output register for one result item.
  always_ff @(posedge clk) begin
    if (emit) begin
      position     <= POS_BITS'(pos);
      vertex       <= VTX_BITS'(cur);
      step_weight  <= step16;
      last_of_tour <= last_pos;
      bad_start    <= bad;
    end
  end

  // A tour always starts from an empty visited map in the row state.
  `NNT_ASSERT_NXT(a_tour_start, clk, rst, in_fire && tour_go, (state == S_ROW) && (visited == '0))
  // Every emitted vertex is one not yet on the tour.
  `NNT_ASSERT_IMP(a_emit_unvisited, clk, rst, emit, !visited[cur])
  // The compare unit never picks a visited vertex.
  `NNT_ASSERT_IMP(a_pick_unvisited, clk, rst, state == S_NEXT, !visited[best_index])
  // Read data only arrives during a row scan.
  `NNT_ASSERT_IMP(a_read_in_scan, clk, rst, rd_v, (state == S_SCAN) || (state == S_DRAIN))
  // The last result returns the block to loading.
  `NNT_ASSERT_NXT(a_last_to_load, clk, rst, emit && last_pos, state == S_LOAD)

endmodule

### sv/nnt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/nnt_argmin.sv
// Shared compare unit that tracks the lightest unvisited edge of a row scan.
module nnt_argmin
  import nnt_pkg::*;
#(
  parameter int IDX_BITS    = 5,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nnt_min_ctl_t           ctl,
  input  logic [IDX_BITS-1:0]    cand_index,
  input  logic [WEIGHT_BITS-1:0] cand_weight,
  input  logic                   cand_skip,
  output logic [IDX_BITS-1:0]    best_index,
  output logic [WEIGHT_BITS-1:0] best_weight
);

  logic found;
  logic take;

  // A strictly lighter edge wins, so ties keep the lower index seen first.
  assign take = ctl.sample && !cand_skip && (!found || (cand_weight < best_weight));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  // Best candidate so far.
  always_ff @(posedge clk) begin
    if (take) begin
      best_index  <= cand_index;
      best_weight <= cand_weight;
    end
  end

endmodule
